[src/rstok_pkg.sv]
package rstok_pkg;

  localparam int MAX_TEXT = 64;
  localparam logic [7:0] STR_LIM = 8'(MAX_TEXT - 1);
  localparam logic [7:0] ID_LIM  = 8'((MAX_TEXT > 2) ? (MAX_TEXT - 1) : 2);

  // result kinds
  localparam logic [1:0] RK_TEXT  = 2'd0;
  localparam logic [1:0] RK_TOKEN = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // token kinds
  localparam logic [4:0] TK_CONST  = 5'd0;
  localparam logic [4:0] TK_ID     = 5'd1;
  localparam logic [4:0] TK_STR    = 5'd2;
  localparam logic [4:0] TK_SLASH  = 5'd20;
  localparam logic [4:0] TK_DSLASH = 5'd21;
  localparam logic [4:0] TK_LT     = 5'd22;
  localparam logic [4:0] TK_LE     = 5'd23;
  localparam logic [4:0] TK_NE     = 5'd24;
  localparam logic [4:0] TK_GT     = 5'd25;
  localparam logic [4:0] TK_GE     = 5'd26;
  localparam logic [4:0] TK_ASSIGN = 5'd27;
  localparam logic [4:0] TK_EQ     = 5'd28;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ID_LONG = 3'd1;
  localparam logic [2:0] ERR_STR_LONG = 3'd2;
  localparam logic [2:0] ERR_UNTERM  = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN = 3'd4;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LN    = 8'h6e;
  localparam logic [7:0] CH_LT_T  = 8'h74;

  typedef enum logic [10:0] {
    M_IDLE     = 11'b000_0000_0001,
    M_PEND     = 11'b000_0000_0010,
    M_ZERO     = 11'b000_0000_0100,
    M_DEC      = 11'b000_0000_1000,
    M_HEXSTART = 11'b000_0001_0000,
    M_HEX      = 11'b000_0010_0000,
    M_ID       = 11'b000_0100_0000,
    M_STR      = 11'b000_1000_0000,
    M_ESC      = 11'b001_0000_0000,
    M_OCT      = 11'b010_0000_0000,
    M_FULL     = 11'b100_0000_0000
  } mode_t;

  typedef enum logic [1:0] {
    OP_SLASH = 2'd0,
    OP_LT    = 2'd1,
    OP_GT    = 2'd2,
    OP_EQ    = 2'd3
  } op_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] acc;
    logic [7:0]  len;
    op_t         op;
    logic [7:0]  esc;
  } scan_state_t;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [4:0]  tkind;
    logic [31:0] value;
    logic [7:0]  tbyte;
    logic [2:0]  err;
  } res_t;

  function automatic scan_state_t idle_state();
    scan_state_t s;
    s.mode = M_IDLE;
    s.acc  = '0;
    s.len  = '0;
    s.op   = OP_SLASH;
    s.esc  = '0;
    return s;
  endfunction

  function automatic res_t mk_res(input logic [1:0] rk, input logic [4:0] tk,
                                  input logic [31:0] v, input logic [7:0] tb,
                                  input logic [2:0] e);
    res_t r;
    r.rkind = rk;
    r.tkind = tk;
    r.value = v;
    r.tbyte = tb;
    r.err   = e;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (is_digit(c)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      // low nibble of a..f / A..F is 1..6
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // {valid, kind}
  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    unique case (c)
      8'h2b:   r = {1'b1, 5'd3};   // +
      8'h2d:   r = {1'b1, 5'd4};   // -
      8'h2a:   r = {1'b1, 5'd5};   // *
      8'h25:   r = {1'b1, 5'd6};   // %
      8'h28:   r = {1'b1, 5'd7};   // (
      8'h29:   r = {1'b1, 5'd8};   // )
      8'h5b:   r = {1'b1, 5'd9};   // [
      8'h5d:   r = {1'b1, 5'd10};  // ]
      8'h7b:   r = {1'b1, 5'd11};  // {
      8'h7d:   r = {1'b1, 5'd12};  // }
      8'h2c:   r = {1'b1, 5'd13};  // ,
      8'h3f:   r = {1'b1, 5'd14};  // ?
      8'h3a:   r = {1'b1, 5'd15};  // :
      8'h5e:   r = {1'b1, 5'd16};  // ^
      8'h5c:   r = {1'b1, 5'd17};  // backslash
      8'h23:   r = {1'b1, 5'd18};  // #
      8'h3b:   r = {1'b1, 5'd19};  // ;
      default: r = '0;
    endcase
    return r;
  endfunction

  // {valid, kind} of a two-character operator
  function automatic logic [5:0] pair_kind(input op_t op, input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    if (op == OP_SLASH && c == CH_SLASH) r = {1'b1, TK_DSLASH};
    else if (op == OP_LT && c == CH_EQ)  r = {1'b1, TK_LE};
    else if (op == OP_LT && c == CH_GT)  r = {1'b1, TK_NE};
    else if (op == OP_GT && c == CH_EQ)  r = {1'b1, TK_GE};
    else if (op == OP_EQ && c == CH_EQ)  r = {1'b1, TK_EQ};
    return r;
  endfunction

  function automatic logic [4:0] single_kind(input op_t op);
    logic [4:0] r;
    unique case (op)
      OP_SLASH: r = TK_SLASH;
      OP_LT:    r = TK_LT;
      OP_GT:    r = TK_GT;
      OP_EQ:    r = TK_ASSIGN;
      default:  r = TK_ASSIGN;
    endcase
    return r;
  endfunction

endpackage

[src/rstok_scanner.sv]
module rstok_scanner (
  input  rstok_pkg::scan_state_t    st,
  input  logic                      kind,
  input  logic [7:0]                ch,
  output rstok_pkg::scan_state_t    st_nxt,
  output rstok_pkg::res_t [2:0]     res,
  output logic [1:0]                n
);
  import rstok_pkg::*;

  logic       eof;
  logic       do_idle;
  logic       raw_go;
  logic       sc_go;
  logic [7:0] sc_byte;
  logic       id_go;
  logic [5:0] pk;
  logic [5:0] prk;
  logic [4:0] hx;
  logic [7:0] oct_len;

  assign eof     = kind || (ch == 8'h00);
  assign pk      = punct_kind(ch);
  assign prk     = pair_kind(st.op, ch);
  assign hx      = hex_val(ch);
  assign oct_len = st.len + 8'd1;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    n       = 2'd0;
    do_idle = 1'b0;
    raw_go  = 1'b0;
    sc_go   = 1'b0;
    sc_byte = ch;
    id_go   = 1'b0;

    if (eof) begin
      unique case (st.mode)
        M_PEND: begin
          res[n] = mk_res(RK_TOKEN, single_kind(st.op), '0, '0, ERR_NONE); n = n + 2'd1;
        end
        M_ZERO: begin
          res[n] = mk_res(RK_TOKEN, TK_CONST, '0, '0, ERR_NONE); n = n + 2'd1;
        end
        M_DEC, M_HEX: begin
          res[n] = mk_res(RK_TOKEN, TK_CONST, st.acc, '0, ERR_NONE); n = n + 2'd1;
        end
        M_HEXSTART: begin
          res[n] = mk_res(RK_ERROR, TK_CONST, '0, CH_ZERO, ERR_UNKNOWN); n = n + 2'd1;
          res[n] = mk_res(RK_TOKEN, TK_CONST, '0, '0, ERR_NONE); n = n + 2'd1;
        end
        M_ID: begin
          res[n] = mk_res(RK_TOKEN, TK_ID, '0, '0, ERR_NONE); n = n + 2'd1;
        end
        M_STR, M_ESC: begin
          res[n] = mk_res(RK_ERROR, TK_CONST, '0, '0, ERR_UNTERM); n = n + 2'd1;
          res[n] = mk_res(RK_TOKEN, TK_STR, '0, '0, ERR_NONE); n = n + 2'd1;
        end
        M_OCT: begin
          // store the pending escape first
          res[n] = mk_res(RK_TEXT, TK_STR, '0, st.esc, ERR_NONE); n = n + 2'd1;
          res[n] = mk_res(RK_ERROR, TK_CONST, '0, '0,
                          (oct_len >= STR_LIM) ? ERR_STR_LONG : ERR_UNTERM);
          n = n + 2'd1;
          res[n] = mk_res(RK_TOKEN, TK_STR, '0, '0, ERR_NONE); n = n + 2'd1;
        end
        M_FULL: begin
          res[n] = mk_res(RK_ERROR, TK_CONST, '0, '0, ERR_STR_LONG); n = n + 2'd1;
          res[n] = mk_res(RK_TOKEN, TK_STR, '0, '0, ERR_NONE); n = n + 2'd1;
        end
        default: begin
        end
      endcase
      st_nxt = idle_state();
    end else begin
      unique case (st.mode)
        M_PEND: begin
          if (prk[5]) begin
            res[n] = mk_res(RK_TOKEN, prk[4:0], '0, '0, ERR_NONE); n = n + 2'd1;
            st_nxt = idle_state();
          end else begin
            res[n] = mk_res(RK_TOKEN, single_kind(st.op), '0, '0, ERR_NONE); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_ZERO: begin
          if (ch == CH_LX || ch == CH_UX) begin
            st_nxt.mode = M_HEXSTART;
          end else if (is_digit(ch)) begin
            st_nxt.acc  = {28'd0, ch[3:0]};
            st_nxt.mode = M_DEC;
          end else begin
            res[n] = mk_res(RK_TOKEN, TK_CONST, '0, '0, ERR_NONE); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit(ch)) begin
            // acc * 10 as two shifts
            st_nxt.acc = {st.acc[28:0], 3'b000} + {st.acc[30:0], 1'b0} + {28'd0, ch[3:0]};
          end else begin
            res[n] = mk_res(RK_TOKEN, TK_CONST, st.acc, '0, ERR_NONE); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_HEXSTART: begin
          if (hx[4]) begin
            st_nxt.acc  = {28'd0, hx[3:0]};
            st_nxt.mode = M_HEX;
          end else begin
            res[n] = mk_res(RK_ERROR, TK_CONST, '0, CH_ZERO, ERR_UNKNOWN); n = n + 2'd1;
            res[n] = mk_res(RK_TOKEN, TK_CONST, '0, '0, ERR_NONE); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_HEX: begin
          if (hx[4]) begin
            st_nxt.acc = {st.acc[27:0], hx[3:0]};
          end else begin
            res[n] = mk_res(RK_TOKEN, TK_CONST, st.acc, '0, ERR_NONE); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_ID: begin
          if (is_alpha(ch) || is_digit(ch)) begin
            id_go = 1'b1;
          end else begin
            res[n] = mk_res(RK_TOKEN, TK_ID, '0, '0, ERR_NONE); n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          raw_go = 1'b1;
        end
        M_ESC: begin
          if (ch == CH_LN) begin
            sc_go = 1'b1; sc_byte = CH_LF;
          end else if (ch == CH_LT_T) begin
            sc_go = 1'b1; sc_byte = CH_TAB;
          end else if (is_octal(ch)) begin
            st_nxt.esc  = {5'd0, ch[2:0]};
            st_nxt.mode = M_OCT;
          end else begin
            sc_go = 1'b1;
          end
        end
        M_OCT: begin
          if (is_octal(ch)) begin
            st_nxt.esc = {st.esc[4:0], ch[2:0]};
          end else begin
            res[n] = mk_res(RK_TEXT, TK_STR, '0, st.esc, ERR_NONE); n = n + 2'd1;
            st_nxt.len = oct_len;
            st_nxt.esc = '0;
            if (oct_len >= STR_LIM) begin
              // full: the ending byte is dropped
              res[n] = mk_res(RK_ERROR, TK_CONST, '0, '0, ERR_STR_LONG); n = n + 2'd1;
              res[n] = mk_res(RK_TOKEN, TK_STR, '0, '0, ERR_NONE); n = n + 2'd1;
              st_nxt = idle_state();
            end else begin
              st_nxt.mode = M_STR;
              raw_go = 1'b1;
            end
          end
        end
        M_FULL: begin
          res[n] = mk_res(RK_ERROR, TK_CONST, '0, '0, ERR_STR_LONG); n = n + 2'd1;
          res[n] = mk_res(RK_TOKEN, TK_STR, '0, '0, ERR_NONE); n = n + 2'd1;
          st_nxt = idle_state();
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // raw string byte
      if (raw_go) begin
        if (ch == CH_QUOTE) begin
          res[n] = mk_res(RK_TOKEN, TK_STR, '0, '0, ERR_NONE); n = n + 2'd1;
          st_nxt = idle_state();
        end else if (ch == CH_BSLASH) begin
          st_nxt.mode = M_ESC;
        end else begin
          sc_go = 1'b1;
        end
      end

      // store one string byte
      if (sc_go) begin
        res[n] = mk_res(RK_TEXT, TK_STR, '0, sc_byte, ERR_NONE); n = n + 2'd1;
        st_nxt.len  = st_nxt.len + 8'd1;
        st_nxt.mode = (st_nxt.len >= STR_LIM) ? M_FULL : M_STR;
      end

      // scan afresh between tokens
      if (do_idle) begin
        st_nxt = idle_state();
        if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR) begin
          st_nxt.mode = M_IDLE;
        end else if (pk[5]) begin
          res[n] = mk_res(RK_TOKEN, pk[4:0], '0, '0, ERR_NONE); n = n + 2'd1;
        end else if (ch == CH_SLASH) begin
          st_nxt.op = OP_SLASH; st_nxt.mode = M_PEND;
        end else if (ch == CH_LT) begin
          st_nxt.op = OP_LT; st_nxt.mode = M_PEND;
        end else if (ch == CH_GT) begin
          st_nxt.op = OP_GT; st_nxt.mode = M_PEND;
        end else if (ch == CH_EQ) begin
          st_nxt.op = OP_EQ; st_nxt.mode = M_PEND;
        end else if (ch == CH_QUOTE) begin
          st_nxt.mode = M_STR;
        end else if (ch == CH_ZERO) begin
          st_nxt.mode = M_ZERO;
        end else if (is_digit(ch)) begin
          st_nxt.acc  = {28'd0, ch[3:0]};
          st_nxt.mode = M_DEC;
        end else if (ch == CH_DOT) begin
          res[n] = mk_res(RK_TOKEN, TK_CONST, '0, '0, ERR_NONE); n = n + 2'd1;
        end else if (is_alpha(ch)) begin
          id_go = 1'b1;
        end else begin
          res[n] = mk_res(RK_ERROR, TK_CONST, '0, ch, ERR_UNKNOWN); n = n + 2'd1;
        end
      end

      // store one identifier byte, cut off at the length limit
      if (id_go) begin
        res[n] = mk_res(RK_TEXT, TK_ID, '0, ch, ERR_NONE); n = n + 2'd1;
        st_nxt.len = st_nxt.len + 8'd1;
        if (st_nxt.len >= ID_LIM) begin
          res[n] = mk_res(RK_ERROR, TK_CONST, '0, '0, ERR_ID_LONG); n = n + 2'd1;
          res[n] = mk_res(RK_TOKEN, TK_ID, '0, '0, ERR_NONE); n = n + 2'd1;
          st_nxt = idle_state();
        end else begin
          st_nxt.mode = M_ID;
        end
      end
    end
  end

endmodule

[src/resource_script_tokenizer_unit.sv]
// The results of an input item are registered: the first is offered in the cycle after its transfer.
// One input item per cycle while each item gives at most one result and the output does not stall;
// an item that gives more results (up to 3) stalls the input until its last result leaves, since
// the result register drains one result per output transfer.
// Reset (rst_n low, synchronous): scanner returns to idle, the result register empties.
module resource_script_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [4:0]  out_token_kind,
  output logic [31:0] out_token_value,
  output logic [7:0]  out_text_byte,
  output logic [2:0]  out_error_code,
  output logic        out_last
);
  import rstok_pkg::*;

  scan_state_t  st_r;
  scan_state_t  st_nxt;
  res_t [2:0]   res_nxt;
  logic [1:0]   n_nxt;
  res_t [2:0]   grp_r;
  logic [1:0]   cnt_r;
  logic [1:0]   idx_r;
  res_t         cur;
  logic         busy;
  logic         out_xfer;
  logic         in_xfer;
  logic         is_last;

  rstok_scanner u_scan (
    .st     (st_r),
    .kind   (in_kind),
    .ch     (in_char_in),
    .st_nxt (st_nxt),
    .res    (res_nxt),
    .n      (n_nxt)
  );

  assign busy     = (cnt_r != 2'd0);
  assign cur      = grp_r[idx_r];
  assign is_last  = (idx_r == (cnt_r - 2'd1));
  assign out_xfer = busy && !out_stall;
  // take the next item once the last result of this one leaves
  assign in_stall = busy && !(out_xfer && is_last);
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid       = busy;
  assign out_result_kind = cur.rkind;
  assign out_token_kind  = cur.tkind;
  assign out_token_value = cur.value;
  assign out_text_byte   = cur.tbyte;
  assign out_error_code  = cur.err;
  assign out_last        = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= idle_state();
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (in_xfer) begin
      st_r  <= st_nxt;
      cnt_r <= n_nxt;
      idx_r <= 2'd0;
    end else if (out_xfer) begin
      if (is_last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      grp_r <= res_nxt;
    end
  end

endmodule

[src/rstok_checker.sv]
module rstok_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [4:0]  out_token_kind,
  input logic [31:0] out_token_value,
  input logic [7:0]  out_text_byte,
  input logic [2:0]  out_error_code,
  input logic        out_last
);
  import rstok_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_token_kind) && $stable(out_token_value) && $stable(out_text_byte) &&
      $stable(out_error_code) && $stable(out_last))
    else $error("stalled result changed");

  // text bytes belong to an identifier or a string and carry no error
  a_text_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_TEXT |->
      (out_token_kind == TK_ID || out_token_kind == TK_STR) &&
      out_error_code == ERR_NONE && out_token_value == 32'd0)
    else $error("bad text result fields");

  // length and termination errors always precede the closing token record
  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_ERROR &&
      (out_error_code == ERR_ID_LONG || out_error_code == ERR_STR_LONG ||
       out_error_code == ERR_UNTERM) |-> !out_last)
    else $error("error not followed by its token record");

  // no new item is taken while a result of the current one is still pending
  a_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken before results drained");

endmodule

bind resource_script_tokenizer_unit rstok_props u_rstok_props (.*);
